[hw/rtl/tbbl_pkg.sv]
// ============================================================================
// tbbl_pkg
// Shared types and constants for the triple box blur line filter.
// ============================================================================
package tbbl_pkg;

    localparam int CH_W     = 8;
    localparam int LANES    = 4;
    localparam int PIX_W    = CH_W * LANES;
    localparam int SUM_W    = 14;
    localparam int RADIUS_W = 5;
    localparam int RECIP_W  = 25;
    localparam int SHIFT    = 24;

    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 5'd1;
    localparam logic [RECIP_W-1:0]  RECIP_RESET  = 25'd5592405;
    localparam logic [SUM_W+RECIP_W:0] ROUND_HALF = 40'd8388608;

    // Register indexes (word address bit 2)
    localparam logic REG_RADIUS = 1'b0;
    localparam logic REG_RECIP  = 1'b1;

    typedef struct packed {
        logic [CH_W-1:0] chan0_in;
        logic [CH_W-1:0] chan1_in;
        logic [CH_W-1:0] chan2_in;
        logic [CH_W-1:0] chan3_in;
        logic            line_end;
    } in_item_t;

    typedef struct packed {
        logic [CH_W-1:0] chan0_out;
        logic [CH_W-1:0] chan1_out;
        logic [CH_W-1:0] chan2_out;
        logic [CH_W-1:0] chan3_out;
        logic            out_line_end;
        logic            short_line;
    } out_item_t;

endpackage

[hw/rtl/triple_box_blur_line.sv]
// ============================================================================
// triple_box_blur_line
// Three cascaded box filters over one line of 4-channel pixels.
// ============================================================================
// Usage notes.
// Input channel (in_valid/in_ready/in_data): one pixel per request, line_end
// on the last pixel of a line. Output channel (out_valid/out_ready/out_data):
// one blurred pixel per request; result k of a line leaves once input k+3r
// has been taken, and the line_end pixel flushes the last 3r results.
// APB port: radius at 0x0, reciprocal (about 2^24/(2r+1)) at 0x4; write only
// while the block is idle.
// Sequencing: every request walks the three passes through one shared
// read-accumulate loop on the pixel rings. A pass runs setup, 2r+1 ring
// reads, drain, scale and commit, each ring having a single read port. A
// line_end pixel repeats the three passes for every result it flushes, and
// no new pixel is taken until all passes of a request are done.
// Reset empties the pipeline and restores radius 1 and its reciprocal; ring
// contents are left as they are. If the receiver stalls, the commit of the
// third pass waits on the output register, holding the sequencer.
// ============================================================================
module triple_box_blur_line #(
    parameter int MAX_RADIUS = 16,
    parameter int RING_DEPTH = 64,
    parameter int MAX_LINE   = 4096
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  tbbl_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output tbbl_pkg::out_item_t out_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam int SW      = $clog2(RING_DEPTH);
    localparam int AW      = SW + 2;
    localparam int PW      = $clog2(2 * MAX_LINE);
    localparam int IW      = PW + 2;
    localparam int CW      = 6;
    localparam int DEPTH_R = (RING_DEPTH - 1) / 2;
    localparam logic [PW-1:0] POS_CAP = PW'(2 * MAX_LINE - 1);
    localparam logic [AW-1:0] DEPTH_A = AW'(RING_DEPTH);
    localparam logic [AW-1:0] DEPTH2  = AW'(2 * RING_DEPTH);
    localparam logic [SW-1:0] LAST_SLOT = SW'(RING_DEPTH - 1);
    localparam logic [tbbl_pkg::RADIUS_W-1:0] MAXR_A = tbbl_pkg::RADIUS_W'(MAX_RADIUS);
    localparam logic [tbbl_pkg::RADIUS_W-1:0] DEPR_A = tbbl_pkg::RADIUS_W'(DEPTH_R);

    // Sequencer states
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SETUP  = 3'd1;
    localparam logic [2:0] ST_TAP    = 3'd2;
    localparam logic [2:0] ST_DRAIN  = 3'd3;
    localparam logic [2:0] ST_SCALE  = 3'd4;
    localparam logic [2:0] ST_COMMIT = 3'd5;

    localparam logic [1:0] PASS_ONE   = 2'd1;
    localparam logic [1:0] PASS_TWO   = 2'd2;
    localparam logic [1:0] PASS_THREE = 2'd3;

    // ring slot of an entry of the given age behind the head
    function automatic logic [SW-1:0] slot_of(input logic [SW-1:0] hd,
                                              input logic [AW-1:0] age);
        logic [AW-1:0] s;
        begin
            s = AW'(hd) + DEPTH2 - age;
            if (s >= DEPTH2)
            begin
                s = s - DEPTH2;
            end
            if (s >= DEPTH_A)
            begin
                s = s - DEPTH_A;
            end
            slot_of = s[SW-1:0];
        end
    endfunction

    function automatic logic [tbbl_pkg::CH_W-1:0] scale_lane(
        input logic [tbbl_pkg::SUM_W-1:0]   s,
        input logic [tbbl_pkg::RECIP_W-1:0] rc);
        logic [tbbl_pkg::SUM_W+tbbl_pkg::RECIP_W:0] p;
        begin
            p = (tbbl_pkg::SUM_W + tbbl_pkg::RECIP_W + 1)'(s) *
                (tbbl_pkg::SUM_W + tbbl_pkg::RECIP_W + 1)'(rc) + tbbl_pkg::ROUND_HALF;
            if (|p[tbbl_pkg::SUM_W+tbbl_pkg::RECIP_W:tbbl_pkg::SHIFT+tbbl_pkg::CH_W])
            begin
                scale_lane = '1;
            end
            else
            begin
                scale_lane = p[tbbl_pkg::SHIFT+tbbl_pkg::CH_W-1:tbbl_pkg::SHIFT];
            end
        end
    endfunction

    // ------------------------------------------------------------------ regs
    logic [tbbl_pkg::RADIUS_W-1:0] radius_reg;
    logic [tbbl_pkg::RECIP_W-1:0]  recip_reg;
    logic [2:0]                    state_reg, state_next;
    logic [SW-1:0]                 head_reg;
    logic [PW-1:0]                 pos_reg;
    logic [PW-1:0]                 j_reg;
    logic                          end_reg;
    logic                          short_reg;
    logic [tbbl_pkg::RADIUS_W-1:0] r_reg;
    logic [CW-1:0]                 v_reg, v_next;
    logic [CW-1:0]                 vmax_reg;
    logic [1:0]                    pass_reg, pass_next;
    logic signed [IW-1:0]          ip_reg;
    logic [CW-1:0]                 tap_reg;
    logic                          rd_valid_reg;
    logic [tbbl_pkg::SUM_W-1:0]    acc_reg [tbbl_pkg::LANES];
    logic [tbbl_pkg::PIX_W-1:0]    q_reg;
    logic                          out_valid_reg;
    tbbl_pkg::out_item_t           out_data_reg;

    // ring memories
    logic [tbbl_pkg::PIX_W-1:0] source_ring [RING_DEPTH];
    logic [tbbl_pkg::PIX_W-1:0] first_ring  [RING_DEPTH];
    logic [tbbl_pkg::PIX_W-1:0] second_ring [RING_DEPTH];
    logic [tbbl_pkg::PIX_W-1:0] src_rd_reg, fst_rd_reg, snd_rd_reg;

    // ------------------------------------------------------------ APB port
    logic cfg_wr;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        case (paddr[2])
            tbbl_pkg::REG_RADIUS: prdata = 32'(radius_reg);
            tbbl_pkg::REG_RECIP:  prdata = 32'(recip_reg);
            default:              prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= tbbl_pkg::RADIUS_RESET;
            recip_reg  <= tbbl_pkg::RECIP_RESET;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == tbbl_pkg::REG_RADIUS)
            begin
                radius_reg <= pwdata[tbbl_pkg::RADIUS_W-1:0];
            end
            else
            begin
                recip_reg <= pwdata[tbbl_pkg::RECIP_W-1:0];
            end
        end
    end

    // ---------------------------------------------------------- datapath
    logic                          in_acc;
    logic [tbbl_pkg::RADIUS_W-1:0] r_use;
    logic [SW-1:0]                 head_inc;
    logic [tbbl_pkg::PIX_W-1:0]    in_pix;
    logic signed [IW-1:0]          j_s, ip_try, off, kk;
    logic                          ip_ok;
    logic [SW-1:0]                 rd_addr, wr_addr;
    logic [tbbl_pkg::PIX_W-1:0]    rd_pix;
    logic                          out_load, out_free, pass_done, wr_one, wr_two;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_acc    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_free  = !out_valid_reg || out_ready;
    assign head_inc  = (head_reg == LAST_SLOT) ? '0 : head_reg + 1'b1;
    assign in_pix    = {in_data.chan3_in, in_data.chan2_in,
                        in_data.chan1_in, in_data.chan0_in};

    always_comb
    begin
        r_use = radius_reg;
        if (r_use > MAXR_A)
        begin
            r_use = MAXR_A;
        end
        if (r_use > DEPR_A)
        begin
            r_use = DEPR_A;
        end
    end

    // centre of the current pass: step (j+v) minus pass * r
    assign j_s = $signed({2'b00, j_reg});
    always_comb
    begin
        case (pass_reg)
            PASS_ONE:   off = IW'(r_reg);
            PASS_TWO:   off = IW'({r_reg, 1'b0});
            PASS_THREE: off = IW'(r_reg) + IW'({r_reg, 1'b0});
            default:    off = '0;
        endcase
    end
    assign ip_try = j_s + IW'(v_reg) - off;
    assign ip_ok  = (ip_try >= 0) && (ip_try <= j_s);

    // tap position, clamped to the line seen so far
    always_comb
    begin
        kk = ip_reg - IW'(r_reg) + IW'(tap_reg);
        if (kk < 0)
        begin
            kk = '0;
        end
        if (kk > j_s)
        begin
            kk = j_s;
        end
    end
    assign rd_addr = slot_of(head_reg, AW'(j_s - kk));
    assign wr_addr = slot_of(head_reg, AW'(j_s - ip_reg));

    always_comb
    begin
        case (pass_reg)
            PASS_ONE: rd_pix = src_rd_reg;
            PASS_TWO: rd_pix = fst_rd_reg;
            default:  rd_pix = snd_rd_reg;
        endcase
    end

    assign wr_one   = (state_reg == ST_COMMIT) && (pass_reg == PASS_ONE);
    assign wr_two   = (state_reg == ST_COMMIT) && (pass_reg == PASS_TWO);
    assign out_load = (state_reg == ST_COMMIT) && (pass_reg == PASS_THREE) && out_free;

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            source_ring[head_inc] <= in_pix;
        end
        src_rd_reg <= source_ring[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (wr_one)
        begin
            first_ring[wr_addr] <= q_reg;
        end
        fst_rd_reg <= first_ring[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (wr_two)
        begin
            second_ring[wr_addr] <= q_reg;
        end
        snd_rd_reg <= second_ring[rd_addr];
    end

    // ----------------------------------------------------------- sequencer
    always_comb
    begin
        state_next = state_reg;
        pass_next  = pass_reg;
        v_next     = v_reg;
        pass_done  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = ST_SETUP;
                    pass_next  = PASS_ONE;
                    v_next     = '0;
                end
            end
            ST_SETUP:
            begin
                if (ip_ok)
                begin
                    state_next = ST_TAP;
                end
                else
                begin
                    pass_done = 1'b1;
                end
            end
            ST_TAP:
            begin
                if (tap_reg == CW'({r_reg, 1'b0}))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:  state_next = ST_SCALE;
            ST_SCALE:  state_next = ST_COMMIT;
            ST_COMMIT:
            begin
                if (pass_reg != PASS_THREE || out_free)
                begin
                    pass_done = 1'b1;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
        if (pass_done)
        begin
            state_next = ST_SETUP;
            if (pass_reg != PASS_THREE)
            begin
                pass_next = pass_reg + 1'b1;
            end
            else if (v_reg == vmax_reg)
            begin
                state_next = ST_IDLE;
            end
            else
            begin
                pass_next = PASS_ONE;
                v_next    = v_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            pos_reg       <= '0;
            pass_reg      <= PASS_ONE;
            v_reg         <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            pass_reg     <= pass_next;
            v_reg        <= v_next;
            rd_valid_reg <= (state_reg == ST_TAP);
            if (in_acc)
            begin
                head_reg <= head_inc;
                if (in_data.line_end)
                begin
                    pos_reg <= '0;
                end
                else if (pos_reg < POS_CAP)
                begin
                    pos_reg <= pos_reg + 1'b1;
                end
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload and working registers
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            j_reg     <= pos_reg;
            end_reg   <= in_data.line_end;
            r_reg     <= r_use;
            vmax_reg  <= in_data.line_end ? CW'(r_use) + CW'({r_use, 1'b0}) : '0;
            short_reg <= in_data.line_end &&
                         ((IW'(pos_reg) + 1) < (IW'(r_use) + IW'({r_use, 1'b0})));
        end
        if (state_reg == ST_SETUP)
        begin
            ip_reg  <= ip_try;
            tap_reg <= '0;
            for (int c = 0; c < tbbl_pkg::LANES; c++)
            begin
                acc_reg[c] <= '0;
            end
        end
        else
        begin
            if (state_reg == ST_TAP)
            begin
                tap_reg <= tap_reg + 1'b1;
            end
            if (rd_valid_reg)
            begin
                for (int c = 0; c < tbbl_pkg::LANES; c++)
                begin
                    acc_reg[c] <= acc_reg[c] +
                                  tbbl_pkg::SUM_W'(rd_pix[c*tbbl_pkg::CH_W +: tbbl_pkg::CH_W]);
                end
            end
        end
        if (state_reg == ST_SCALE)
        begin
            for (int c = 0; c < tbbl_pkg::LANES; c++)
            begin
                q_reg[c*tbbl_pkg::CH_W +: tbbl_pkg::CH_W] <= scale_lane(acc_reg[c], recip_reg);
            end
        end
        if (out_load)
        begin
            out_data_reg.chan0_out    <= q_reg[7:0];
            out_data_reg.chan1_out    <= q_reg[15:8];
            out_data_reg.chan2_out    <= q_reg[23:16];
            out_data_reg.chan3_out    <= q_reg[31:24];
            out_data_reg.out_line_end <= end_reg && (ip_reg == j_s);
            out_data_reg.short_line   <= short_reg;
        end
    end

`ifndef ASSERT_OFF
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("sequencer stayed idle after taking a pixel");
    a_tap_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_TAP |-> tap_reg <= CW'({r_reg, 1'b0}))
        else $error("tap counter ran past the window");
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid_reg || out_ready))
        else $error("output register overwritten while held");
`endif

endmodule

[verif/tb_triple_box_blur_line.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_triple_box_blur_line
// Self-checking bench for the triple box blur line filter. A behavioural
// predictor runs the three skewed box passes on every pixel request and
// queues the blurred pixels it expects. A checker compares each output
// request field by field against the oldest entry in that queue.
// ----------------------------------------------------------------------------
module tb_triple_box_blur_line;

    localparam int  RING       = 64;
    localparam int  LINE_MAX   = 64;        // small line limit so long lines stay short
    localparam int  RADIUS_CAP = 16;        // smallest of MAX_RADIUS and (RING-1)/2
    localparam int  POS_LIMIT  = 2 * LINE_MAX - 1;
    localparam int  IDLE_LIMIT = 20000;     // above the longest line_end flush
    localparam int  SETTLE     = 130;       // beyond one non-flush pixel at r=16
    localparam logic [2:0] ADDR_RADIUS = {tbbl_pkg::REG_RADIUS, 2'b00};
    localparam logic [2:0] ADDR_RECIP  = {tbbl_pkg::REG_RECIP, 2'b00};

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    tbbl_pkg::in_item_t  in_data;
    logic                out_valid;
    logic                out_ready;
    tbbl_pkg::out_item_t out_data;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [2:0]          paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    triple_box_blur_line #(
        .MAX_LINE  (LINE_MAX)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------------
    // Predictor state: its own copy of the registers, the three pixel rings
    // and the line position.
    // ------------------------------------------------------------------------
    logic [tbbl_pkg::RADIUS_W-1:0] blur_radius;
    logic [tbbl_pkg::RECIP_W-1:0]  blur_recip;
    logic [31:0]         src_ring [RING];
    logic [31:0]         fst_ring [RING];
    logic [31:0]         snd_ring [RING];
    int                  line_pos;
    int                  ring_head;

    tbbl_pkg::out_item_t blurred_due[$];

    int  errors;
    int  pixels_sent;
    int  pixels_blurred;
    int  lines_sent;
    int  idle_cycles;
    int  hold_request;
    bit  rx_jitter;
    bit  tx_jitter;
    bit  in_taken;
    bit  out_taken;

    function automatic int radius_used();
        int r;
        r = blur_radius;
        if (r > RADIUS_CAP)
            r = RADIUS_CAP;
        return r;
    endfunction

    function automatic int slot_at(int newest, int k);
        int age;
        age = newest - k;
        if (age < 0)
            age = 0;
        if (age > 2 * RING)
            age = 2 * RING;
        return (ring_head + 2 * RING - age) % RING;
    endfunction

    // Window sum of one pass; edges repeat the first and the newest value.
    function automatic logic [4*tbbl_pkg::SUM_W-1:0] box_sum(int pass, int newest, int centre,
                                                             int r);
        int          acc [4];
        int          kk;
        logic [31:0] px;
        logic [4*tbbl_pkg::SUM_W-1:0] packed_sum;
        for (int c = 0; c < 4; c++)
            acc[c] = 0;
        for (int k = centre - r; k <= centre + r; k++)
        begin
            kk = (k < 0) ? 0 : ((k > newest) ? newest : k);
            case (pass)
                0:       px = src_ring[slot_at(newest, kk)];
                1:       px = fst_ring[slot_at(newest, kk)];
                default: px = snd_ring[slot_at(newest, kk)];
            endcase
            for (int c = 0; c < 4; c++)
                acc[c] += px[8*c +: 8];
        end
        for (int c = 0; c < 4; c++)
            packed_sum[tbbl_pkg::SUM_W*c +: tbbl_pkg::SUM_W] = acc[c][tbbl_pkg::SUM_W-1:0];
        return packed_sum;
    endfunction

    // Rounded reciprocal multiply, saturated to 8 bits per channel.
    function automatic logic [31:0] rescale(logic [4*tbbl_pkg::SUM_W-1:0] sums);
        longint unsigned q;
        logic [31:0]     px;
        for (int c = 0; c < 4; c++)
        begin
            q = (longint'(sums[tbbl_pkg::SUM_W*c +: tbbl_pkg::SUM_W]) * longint'(blur_recip)
                 + (64'd1 << 23)) >> 24;
            px[8*c +: 8] = (q > 255) ? 8'hFF : q[7:0];
        end
        return px;
    endfunction

    // One time step of the skewed passes; the third pass yields a pixel.
    task automatic blur_step(int newest, int j, int r, bit ending, bit is_short);
        int          i1;
        int          i2;
        int          i3;
        logic [31:0] px;
        tbbl_pkg::out_item_t e;
        i1 = j - r;
        i2 = j - 2 * r;
        i3 = j - 3 * r;
        if (i1 >= 0 && i1 <= newest)
            fst_ring[slot_at(newest, i1)] = rescale(box_sum(0, newest, i1, r));
        if (i2 >= 0 && i2 <= newest)
            snd_ring[slot_at(newest, i2)] = rescale(box_sum(1, newest, i2, r));
        if (i3 >= 0 && i3 <= newest)
        begin
            px             = rescale(box_sum(2, newest, i3, r));
            e.chan0_out    = px[7:0];
            e.chan1_out    = px[15:8];
            e.chan2_out    = px[23:16];
            e.chan3_out    = px[31:24];
            e.out_line_end = ending && (i3 == newest);
            e.short_line   = is_short;
            blurred_due.push_back(e);
        end
    endtask

    task automatic predict_pixel(tbbl_pkg::in_item_t p);
        int r;
        int j;
        r = radius_used();
        j = line_pos;
        ring_head = (ring_head + 1) % RING;
        src_ring[ring_head] = {p.chan3_in, p.chan2_in, p.chan1_in, p.chan0_in};
        if (!p.line_end)
        begin
            blur_step(j, j, r, 1'b0, 1'b0);
            line_pos = (j < POS_LIMIT) ? j + 1 : POS_LIMIT;
        end
        else
        begin
            // line_end flushes the 3r results still held back
            for (int v = 0; v <= 3 * r; v++)
                blur_step(j, j + v, r, 1'b1, (j + 1) < 3 * r);
            line_pos = 0;
        end
    endtask

    // ------------------------------------------------------------------------
    // Handshake sampling at the falling edge: inputs and outputs are stable
    // there, so what is seen is what the next rising edge accepts.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        in_taken  = in_valid && in_ready;
        out_taken = out_valid && out_ready;
    end

    // Result checker: each output request against the oldest expectation.
    always @(negedge clk)
    begin
        tbbl_pkg::out_item_t e;
        if (rst_n && out_valid && out_ready)
        begin
            pixels_blurred++;
            if (blurred_due.size() == 0)
            begin
                $error("unexpected blurred pixel %h", out_data);
                errors++;
            end
            else
            begin
                e = blurred_due.pop_front();
                if (out_data.chan0_out !== e.chan0_out)
                begin
                    $error("chan0_out expected %0d got %0d", e.chan0_out, out_data.chan0_out);
                    errors++;
                end
                if (out_data.chan1_out !== e.chan1_out)
                begin
                    $error("chan1_out expected %0d got %0d", e.chan1_out, out_data.chan1_out);
                    errors++;
                end
                if (out_data.chan2_out !== e.chan2_out)
                begin
                    $error("chan2_out expected %0d got %0d", e.chan2_out, out_data.chan2_out);
                    errors++;
                end
                if (out_data.chan3_out !== e.chan3_out)
                begin
                    $error("chan3_out expected %0d got %0d", e.chan3_out, out_data.chan3_out);
                    errors++;
                end
                if (out_data.out_line_end !== e.out_line_end)
                begin
                    $error("out_line_end expected %0d got %0d",
                           e.out_line_end, out_data.out_line_end);
                    errors++;
                end
                if (out_data.short_line !== e.short_line)
                begin
                    $error("short_line expected %0d got %0d", e.short_line, out_data.short_line);
                    errors++;
                end
            end
        end
    end

    // Mostly no gap, some short ones, a few long ones.
    function automatic int gap_length();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 65)
            return 0;
        else if (pick < 93)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    // Receiver: random stalls, or one long hold when a test asks for it.
    always @(posedge clk)
    begin
        int rx_gap;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            rx_gap = 0;
        end
        else if (hold_request > 0)
        begin
            out_ready <= 1'b0;
            hold_request--;
        end
        else if (rx_jitter && rx_gap > 0)
        begin
            out_ready <= 1'b0;
            rx_gap--;
        end
        else
        begin
            out_ready <= 1'b1;
            if (rx_jitter)
                rx_gap = gap_length();
        end
    end

    // Watchdog on cycles with no request accepted anywhere.
    always @(posedge clk)
    begin
        if (in_taken || out_taken || (psel && penable))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Shared stimulus tasks
    // ------------------------------------------------------------------------
    task automatic send_pixel(tbbl_pkg::in_item_t p);
        int gap;
        gap = tx_jitter ? gap_length() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= p;
        predict_pixel(p);
        pixels_sent++;
        if (p.line_end)
            lines_sent++;
        do
            @(posedge clk);
        while (!in_taken);
    endtask

    function automatic tbbl_pkg::in_item_t random_pixel(bit last);
        tbbl_pkg::in_item_t p;
        p          = {$urandom, 1'b0};
        p.line_end = last;
        return p;
    endfunction

    task automatic send_line(int len);
        for (int i = 0; i < len; i++)
            send_pixel(random_pixel(i == len - 1));
    endtask

    // Sender pauses until every expected pixel is out, then lets the block settle.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (blurred_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic apb_write(logic [2:0] addr, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_RADIUS)
            blur_radius = value[tbbl_pkg::RADIUS_W-1:0];
        else
            blur_recip = value[tbbl_pkg::RECIP_W-1:0];
    endtask

    // Radius plus the matching rounded reciprocal of the clamped window.
    task automatic set_radius(int r);
        int w;
        w = 2 * ((r > RADIUS_CAP) ? RADIUS_CAP : r) + 1;
        wait_drained();
        apb_write(ADDR_RADIUS, r);
        apb_write(ADDR_RECIP, ((1 << 24) + w / 2) / w);
    endtask

    function automatic tbbl_pkg::in_item_t flat_pixel(logic [7:0] v, bit last);
        tbbl_pkg::in_item_t p;
        p.chan0_in = v;
        p.chan1_in = v;
        p.chan2_in = v;
        p.chan3_in = v;
        p.line_end = last;
        return p;
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset radius 1: hard black/white steps and per-channel extremes.
    task automatic test_reset_extremes();
        tbbl_pkg::in_item_t p;
        send_pixel(flat_pixel(8'h00, 1'b0));
        send_pixel(flat_pixel(8'hFF, 1'b0));
        p = '{8'hFF, 8'h00, 8'hAA, 8'h55, 1'b0};
        send_pixel(p);
        p = '{8'h00, 8'hFF, 8'h55, 8'hAA, 1'b0};
        send_pixel(p);
        send_pixel(flat_pixel(8'hFF, 1'b1));
    endtask

    // Lines shorter than 3r, down to a single pixel.
    task automatic test_short_lines();
        set_radius(3);
        send_pixel(flat_pixel(8'h80, 1'b1));
        send_line(4);
    endtask

    // Radius 0 with reciprocal 2^24: the blur is the identity.
    task automatic test_radius_zero();
        set_radius(0);
        send_line(3);
    endtask

    // Radius 31 is clamped to 16.
    task automatic test_radius_clamp();
        set_radius(31);
        send_line(5);
    endtask

    // Reciprocal at its extremes: saturation at 255 and all-zero output.
    task automatic test_reciprocal_extremes();
        wait_drained();
        apb_write(ADDR_RADIUS, 2);
        apb_write(ADDR_RECIP, 32'h1FF_FFFF);
        send_pixel(flat_pixel(8'hFF, 1'b0));
        send_pixel(flat_pixel(8'h01, 1'b1));
        wait_drained();
        apb_write(ADDR_RECIP, 0);
        send_line(3);
        wait_drained();
        apb_write(ADDR_RECIP, 1 << 24);
        send_line(2);
    endtask

    // A line past the line limit and its position cap, at radius 0.
    task automatic test_long_line();
        set_radius(0);
        tx_jitter = 1'b0;
        rx_jitter = 1'b0;
        send_line(2 * LINE_MAX + 2);
        tx_jitter = 1'b1;
        rx_jitter = 1'b1;
    endtask

    // Receiver holds off while the sender keeps pushing, so the block backs up.
    task automatic test_backpressure();
        set_radius(2);
        hold_request = 400;
        send_line(20);
    endtask

    // Random lines under a range of settings; mostly small radii.
    task automatic test_random_lines();
        int sent;
        int r;
        int len;
        sent = 0;
        while (sent < 40)
        begin
            case ($urandom_range(0, 9))
                0:       r = 16;
                1:       r = $urandom_range(17, 31);
                2:       r = $urandom_range(5, 15);
                default: r = $urandom_range(0, 4);
            endcase
            set_radius(r);
            if ($urandom_range(0, 5) == 0)
                apb_write(ADDR_RECIP, $urandom_range(0, 32'h1FF_FFFF));
            len = $urandom_range(0, 3) == 0 ? $urandom_range(1, 4) : $urandom_range(5, 30);
            send_line(len);
            sent += len;
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_data      = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        blur_radius  = tbbl_pkg::RADIUS_RESET;
        blur_recip   = tbbl_pkg::RECIP_RESET;
        line_pos     = 0;
        ring_head    = 0;
        errors       = 0;
        pixels_sent  = 0;
        pixels_blurred = 0;
        lines_sent   = 0;
        idle_cycles  = 0;
        hold_request = 0;
        rx_jitter    = 1'b1;
        tx_jitter    = 1'b1;
        in_taken     = 1'b0;
        out_taken    = 1'b0;
        for (int i = 0; i < RING; i++)
        begin
            src_ring[i] = '0;
            fst_ring[i] = '0;
            snd_ring[i] = '0;
        end
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_extremes();
        test_short_lines();
        test_radius_zero();
        test_radius_clamp();
        test_reciprocal_extremes();
        test_backpressure();
        test_long_line();
        test_random_lines();

        wait_drained();
        $display("Blurred %0d pixels from %0d requests over %0d lines;", pixels_blurred,
                 pixels_sent, lines_sent);
        $display("radii 0 to 31, short and long lines, reciprocal extremes, long stall.");
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

[files.f]
hw/rtl/tbbl_pkg.sv
hw/rtl/triple_box_blur_line.sv
verif/tb_triple_box_blur_line.sv
